>>> src/sps_pkg.sv
// shared types and constants for the slotted page cell store
// used by sps_ctrl, sps_datapath and slotted_page_cell_store_core
package sps_pkg;

   localparam int SLOT_BYTES = 4;

   typedef enum logic [2:0] {
      FN_INIT     = 3'd0,
      FN_RESERVE  = 3'd1,
      FN_WRITE    = 3'd2,
      FN_REMOVE   = 3'd3,
      FN_READ     = 3'd4,
      FN_COMPACT  = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      RS_OK      = 2'd0,
      RS_NO_ROOM = 2'd1,
      RS_BAD     = 2'd2,
      RS_ABSENT  = 2'd3
   } result_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT,
      OP_ZERO,
      OP_SLOT_WR,
      OP_SLOT_RD,
      OP_SLOT_CAP,
      OP_RES_COMMIT,
      OP_BYTE_WR,
      OP_RD_CHECK,
      OP_RD_DATA,
      OP_CMP_START,
      OP_CMP_SKIP,
      OP_CMP_PLACE,
      OP_MV_RD,
      OP_MV_WR,
      OP_CMP_ADV,
      OP_Z1_START,
      OP_Z2_START,
      OP_CMP_FINISH,
      OP_RESP
   } dp_op_type;

   typedef enum logic [4:0] {
      S_RST_INIT,
      S_RST_CLEAR,
      S_IDLE,
      S_DECODE,
      S_INIT_CLEAR,
      S_RES_WR,
      S_RES_COMMIT,
      S_BYTE_WR,
      S_RM_WR,
      S_RD_SLOT,
      S_RD_CAP,
      S_RD_CHECK,
      S_RD_DATA,
      S_CMP_START,
      S_CMP_SCAN,
      S_CMP_SLOT,
      S_CMP_CAP,
      S_CMP_EVAL,
      S_CMP_MV_RD,
      S_CMP_MV_WR,
      S_CMP_SLOT_WR,
      S_CMP_ADV,
      S_CMP_Z1_START,
      S_CMP_Z1,
      S_CMP_Z2_START,
      S_CMP_Z2,
      S_CMP_FINISH,
      S_RESP
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       reject;
      logic       dirty;
      logic [1:0] k;
      logic       rd_hit;
      logic       loc_zero;
      logic       cmp_full;
      logic       scan_end;
      logic       cnt_zero;
      logic       z1_done;
      logic       z2_done;
      logic       clr_done;
      logic       out_free;
   } dp_stat_type;

endpackage

>>> src/slotted_page_cell_store_core.sv
// top level of the slotted page cell store
// depends on sps_pkg, sps_ctrl and sps_datapath
//
// One request is worked at a time over a single-port byte memory of PAGE_BYTES
// bytes with registered read data. After reset, and for init, the memory is
// cleared one byte a cycle, with no request taken meanwhile. A read skips the
// data fetch when the cell is absent or the index is past its end. Compaction
// moves each live cell byte by byte and zeroes the stale slots and the freed
// cell area. A finished result waits in an output register while the next
// request is taken.
module slotted_page_cell_store_core #(
   parameter int PAGE_BYTES   = 4096,
   parameter int HEADER_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // cell length, data_byte, slot_offset, byte_index
   input  logic [2:0]  req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // new_slot_offset, read_data, stored_length,
                                   // free_bytes, compact_pending
   output logic [1:0]  rsp_tuser   // status
);

   sps_pkg::dp_cmd_type  cmd;
   sps_pkg::dp_stat_type stat;

   sps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sps_datapath #(
      .PAGE_BYTES   (PAGE_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> src/sps_ctrl.sv
// controller state machine of the slotted page cell store
// depends on sps_pkg; drives sps_datapath by one micro-op per cycle
module sps_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sps_pkg::dp_stat_type stat,
   output sps_pkg::dp_cmd_type  cmd
);

   sps_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sps_pkg::S_RST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = sps_pkg::OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         sps_pkg::S_RST_INIT: begin
            cmd.op   = sps_pkg::OP_INIT;
            state_in = sps_pkg::S_RST_CLEAR;
         end
         sps_pkg::S_RST_CLEAR: begin
            if (stat.clr_done) begin
               state_in = sps_pkg::S_IDLE;
            end else begin
               cmd.op = sps_pkg::OP_ZERO;
            end
         end
         sps_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = sps_pkg::OP_LOAD;
               state_in = sps_pkg::S_DECODE;
            end
         end
         sps_pkg::S_DECODE: begin
            if (stat.reject) begin
               state_in = sps_pkg::S_RESP;
            end else begin
               unique case (sps_pkg::func_type'(stat.func))
                  sps_pkg::FN_INIT: begin
                     cmd.op   = sps_pkg::OP_INIT;
                     state_in = sps_pkg::S_INIT_CLEAR;
                  end
                  sps_pkg::FN_RESERVE: state_in = sps_pkg::S_RES_WR;
                  sps_pkg::FN_WRITE:   state_in = sps_pkg::S_BYTE_WR;
                  sps_pkg::FN_REMOVE:  state_in = sps_pkg::S_RM_WR;
                  sps_pkg::FN_READ:    state_in = sps_pkg::S_RD_SLOT;
                  sps_pkg::FN_COMPACT: begin
                     state_in = stat.dirty ? sps_pkg::S_CMP_START : sps_pkg::S_RESP;
                  end
                  default: state_in = sps_pkg::S_RESP;
               endcase
            end
         end
         sps_pkg::S_INIT_CLEAR: begin
            if (stat.clr_done) begin
               state_in = sps_pkg::S_RESP;
            end else begin
               cmd.op = sps_pkg::OP_ZERO;
            end
         end
         sps_pkg::S_RES_WR: begin
            cmd.op = sps_pkg::OP_SLOT_WR;
            if (stat.k == 2'd3) begin
               state_in = sps_pkg::S_RES_COMMIT;
            end
         end
         sps_pkg::S_RES_COMMIT: begin
            cmd.op   = sps_pkg::OP_RES_COMMIT;
            state_in = sps_pkg::S_RESP;
         end
         sps_pkg::S_BYTE_WR: begin
            cmd.op   = sps_pkg::OP_BYTE_WR;
            state_in = sps_pkg::S_RESP;
         end
         sps_pkg::S_RM_WR: begin
            cmd.op = sps_pkg::OP_SLOT_WR;
            if (stat.k == 2'd1) begin
               state_in = sps_pkg::S_RESP;
            end
         end
         sps_pkg::S_RD_SLOT: begin
            cmd.op = sps_pkg::OP_SLOT_RD;
            if (stat.k == 2'd3) begin
               state_in = sps_pkg::S_RD_CAP;
            end
         end
         sps_pkg::S_RD_CAP: begin
            cmd.op   = sps_pkg::OP_SLOT_CAP;
            state_in = sps_pkg::S_RD_CHECK;
         end
         sps_pkg::S_RD_CHECK: begin
            cmd.op   = sps_pkg::OP_RD_CHECK;
            state_in = stat.rd_hit ? sps_pkg::S_RD_DATA : sps_pkg::S_RESP;
         end
         sps_pkg::S_RD_DATA: begin
            cmd.op   = sps_pkg::OP_RD_DATA;
            state_in = sps_pkg::S_RESP;
         end
         sps_pkg::S_CMP_START: begin
            cmd.op   = sps_pkg::OP_CMP_START;
            state_in = sps_pkg::S_CMP_SCAN;
         end
         sps_pkg::S_CMP_SCAN: begin
            state_in = stat.scan_end ? sps_pkg::S_CMP_Z1_START : sps_pkg::S_CMP_SLOT;
         end
         sps_pkg::S_CMP_SLOT: begin
            cmd.op = sps_pkg::OP_SLOT_RD;
            if (stat.k == 2'd3) begin
               state_in = sps_pkg::S_CMP_CAP;
            end
         end
         sps_pkg::S_CMP_CAP: begin
            cmd.op   = sps_pkg::OP_SLOT_CAP;
            state_in = sps_pkg::S_CMP_EVAL;
         end
         sps_pkg::S_CMP_EVAL: begin
            if (stat.loc_zero) begin
               cmd.op   = sps_pkg::OP_CMP_SKIP;
               state_in = sps_pkg::S_CMP_SCAN;
            end else if (stat.cmp_full) begin
               state_in = sps_pkg::S_CMP_Z1_START;
            end else begin
               cmd.op   = sps_pkg::OP_CMP_PLACE;
               state_in = sps_pkg::S_CMP_MV_RD;
            end
         end
         sps_pkg::S_CMP_MV_RD: begin
            if (stat.cnt_zero) begin
               state_in = sps_pkg::S_CMP_SLOT_WR;
            end else begin
               cmd.op   = sps_pkg::OP_MV_RD;
               state_in = sps_pkg::S_CMP_MV_WR;
            end
         end
         sps_pkg::S_CMP_MV_WR: begin
            cmd.op   = sps_pkg::OP_MV_WR;
            state_in = sps_pkg::S_CMP_MV_RD;
         end
         sps_pkg::S_CMP_SLOT_WR: begin
            cmd.op = sps_pkg::OP_SLOT_WR;
            if (stat.k == 2'd3) begin
               state_in = sps_pkg::S_CMP_ADV;
            end
         end
         sps_pkg::S_CMP_ADV: begin
            cmd.op   = sps_pkg::OP_CMP_ADV;
            state_in = sps_pkg::S_CMP_SCAN;
         end
         sps_pkg::S_CMP_Z1_START: begin
            cmd.op   = sps_pkg::OP_Z1_START;
            state_in = sps_pkg::S_CMP_Z1;
         end
         sps_pkg::S_CMP_Z1: begin
            if (stat.z1_done) begin
               state_in = sps_pkg::S_CMP_Z2_START;
            end else begin
               cmd.op = sps_pkg::OP_ZERO;
            end
         end
         sps_pkg::S_CMP_Z2_START: begin
            cmd.op   = sps_pkg::OP_Z2_START;
            state_in = sps_pkg::S_CMP_Z2;
         end
         sps_pkg::S_CMP_Z2: begin
            if (stat.z2_done) begin
               state_in = sps_pkg::S_CMP_FINISH;
            end else begin
               cmd.op = sps_pkg::OP_ZERO;
            end
         end
         sps_pkg::S_CMP_FINISH: begin
            cmd.op   = sps_pkg::OP_CMP_FINISH;
            state_in = sps_pkg::S_RESP;
         end
         sps_pkg::S_RESP: begin
            if (stat.out_free) begin
               cmd.op   = sps_pkg::OP_RESP;
               state_in = sps_pkg::S_IDLE;
            end
         end
         default: state_in = sps_pkg::S_RST_INIT;
      endcase
   end

endmodule

>>> src/sps_datapath.sv
// datapath of the slotted page cell store: page memory, page registers,
// compaction pointers and the result register; depends on sps_pkg
module sps_datapath #(
   parameter int PAGE_BYTES   = 4096,
   parameter int HEADER_BYTES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [47:0]          req_tdata,
   input  logic [2:0]           req_tuser,
   input  sps_pkg::dp_cmd_type  cmd,
   output sps_pkg::dp_stat_type stat,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,
   output logic [1:0]           rsp_tuser
);

   localparam int AW = $clog2(PAGE_BYTES);
   localparam int PW = AW + 1;
   localparam int EW = ((PW > 16) ? PW : 16) + 2;

   logic [7:0] mem [PAGE_BYTES];

   logic          mem_we, mem_re;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [7:0]    mem_wd;
   logic [7:0]    rd_q_ff;

   // page registers
   logic [PW-1:0] pe_ff, pe_in, cb_ff, cb_in, space_ff, space_in, cursor_ff, cursor_in;
   logic          dirty_ff, dirty_in, rsp_valid_ff, rsp_valid_in;
   logic [13:0]   pending_ff, pending_in;
   logic [1:0]    k_ff, k_in;

   // request and working registers
   logic [2:0]    func_ff, func_in;
   logic [7:0]    dbyte_ff, dbyte_in;
   logic [11:0]   bidx_ff, bidx_in, nslot_ff, nslot_in;
   logic [7:0]    rdata_ff, rdata_in;
   logic [12:0]   slen_ff, slen_in;
   sps_pkg::result_type res_ff, res_in;
   logic [PW-1:0] wbase_ff, wbase_in, rbase_ff, rbase_in, clr_ff, clr_in;
   logic [PW-1:0] old_pe_ff, old_pe_in, old_cb_ff, old_cb_in;
   logic [15:0]   wloc_ff, wloc_in, wsize_ff, wsize_in, loc_ff, loc_in, size_ff, size_in;
   logic [15:0]   cnt_ff, cnt_in, last_loc_ff, last_loc_in, last_size_ff, last_size_in;
   logic          last_live_ff, last_live_in;
   logic [47:0]   out_data_ff, out_data_in;
   logic [1:0]    out_user_ff, out_user_in;

   // request fields
   logic [12:0] rq_csize;
   logic [7:0]  rq_dbyte;
   logic [11:0] rq_soff, rq_bidx;
   logic [EW-1:0] soff_e, soff_rel;
   logic        slot_ok, no_room;
   logic [7:0]  slot_byte;

   assign rq_csize = req_tdata[12:0];
   assign rq_dbyte = req_tdata[20:13];
   assign rq_soff  = req_tdata[32:21];
   assign rq_bidx  = req_tdata[44:33];

   assign soff_e   = EW'(rq_soff);
   assign soff_rel = soff_e - EW'(HEADER_BYTES);
   assign slot_ok  = (soff_e >= EW'(HEADER_BYTES))
                  && (soff_e + EW'(sps_pkg::SLOT_BYTES) <= EW'(pe_ff))
                  && (soff_rel[1:0] == 2'b00);
   assign no_room  = EW'(space_ff) < EW'(rq_csize) + EW'(sps_pkg::SLOT_BYTES);

   always_comb begin
      case (k_ff)
         2'd0:    slot_byte = wloc_ff[7:0];
         2'd1:    slot_byte = wloc_ff[15:8];
         2'd2:    slot_byte = wsize_ff[7:0];
         default: slot_byte = wsize_ff[15:8];
      endcase
   end

   // status back to the controller
   assign stat.func     = func_ff;
   assign stat.reject   = (res_ff != sps_pkg::RS_OK);
   assign stat.dirty    = dirty_ff;
   assign stat.k        = k_ff;
   assign stat.rd_hit   = (loc_ff != 16'd0) && ({4'd0, bidx_ff} < size_ff);
   assign stat.loc_zero = (loc_ff == 16'd0);
   assign stat.cmp_full = (EW'(wloc_ff) < EW'(wbase_ff))
                       || (EW'(wloc_ff) - EW'(wbase_ff)
                           < EW'(size_ff) + EW'(sps_pkg::SLOT_BYTES));
   assign stat.scan_end = EW'(rbase_ff) >= EW'(old_pe_ff);
   assign stat.cnt_zero = (cnt_ff == 16'd0);
   assign stat.z1_done  = EW'(clr_ff) >= EW'(old_pe_ff);
   assign stat.z2_done  = EW'(clr_ff) >= EW'(wloc_ff);
   assign stat.clr_done = EW'(clr_ff) == EW'(PAGE_BYTES);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_wa = AW'(clr_ff);
      mem_ra = AW'(EW'(rbase_ff) + EW'(k_ff));
      mem_wd = 8'd0;

      pe_in        = pe_ff;
      cb_in        = cb_ff;
      space_in     = space_ff;
      cursor_in    = cursor_ff;
      dirty_in     = dirty_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      k_in         = 2'd0;
      func_in      = func_ff;
      dbyte_in     = dbyte_ff;
      bidx_in      = bidx_ff;
      nslot_in     = nslot_ff;
      rdata_in     = rdata_ff;
      slen_in      = slen_ff;
      res_in       = res_ff;
      wbase_in     = wbase_ff;
      rbase_in     = rbase_ff;
      clr_in       = clr_ff;
      old_pe_in    = old_pe_ff;
      old_cb_in    = old_cb_ff;
      wloc_in      = wloc_ff;
      wsize_in     = wsize_ff;
      loc_in       = loc_ff;
      size_in      = size_ff;
      cnt_in       = cnt_ff;
      last_loc_in  = last_loc_ff;
      last_size_in = last_size_ff;
      last_live_in = last_live_ff;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;

      case (cmd.op)
         sps_pkg::OP_LOAD: begin
            func_in  = req_tuser;
            dbyte_in = rq_dbyte;
            bidx_in  = rq_bidx;
            nslot_in = 12'd0;
            rdata_in = 8'd0;
            slen_in  = 13'd0;
            rbase_in = PW'(rq_soff);
            wsize_in = 16'(rq_csize);
            res_in   = sps_pkg::RS_OK;
            if (req_tuser == sps_pkg::FN_REMOVE) begin
               wbase_in = PW'(rq_soff);
               wloc_in  = 16'd0;
            end else begin
               wbase_in = pe_ff;
               wloc_in  = 16'(EW'(cb_ff) - EW'(rq_csize));
            end
            case (req_tuser)
               sps_pkg::FN_INIT, sps_pkg::FN_COMPACT: res_in = sps_pkg::RS_OK;
               sps_pkg::FN_RESERVE: begin
                  if (no_room) res_in = sps_pkg::RS_NO_ROOM;
               end
               sps_pkg::FN_WRITE: begin
                  if (pending_ff == 14'd0) res_in = sps_pkg::RS_BAD;
               end
               sps_pkg::FN_REMOVE: begin
                  if (slot_ok) dirty_in = 1'b1;
                  else res_in = sps_pkg::RS_BAD;
               end
               sps_pkg::FN_READ: begin
                  if (!slot_ok) res_in = sps_pkg::RS_BAD;
               end
               default: res_in = sps_pkg::RS_BAD;
            endcase
         end
         sps_pkg::OP_INIT: begin
            pe_in      = PW'(HEADER_BYTES);
            cb_in      = PW'(PAGE_BYTES - 1);
            space_in   = PW'(PAGE_BYTES - 1 - HEADER_BYTES);
            dirty_in   = 1'b0;
            cursor_in  = '0;
            pending_in = 14'd0;
            clr_in     = '0;
         end
         sps_pkg::OP_ZERO: begin
            mem_we = 1'b1;
            mem_wa = AW'(clr_ff);
            clr_in = clr_ff + PW'(1);
         end
         sps_pkg::OP_SLOT_WR: begin
            mem_we = 1'b1;
            mem_wa = AW'(EW'(wbase_ff) + EW'(k_ff));
            mem_wd = slot_byte;
            k_in   = k_ff + 2'd1;
         end
         sps_pkg::OP_SLOT_RD: begin
            mem_re = 1'b1;
            k_in   = k_ff + 2'd1;
            case (k_ff)
               2'd1:    loc_in[7:0]  = rd_q_ff;
               2'd2:    loc_in[15:8] = rd_q_ff;
               2'd3:    size_in[7:0] = rd_q_ff;
               default: loc_in       = loc_ff;
            endcase
         end
         sps_pkg::OP_SLOT_CAP: begin
            size_in[15:8] = rd_q_ff;
         end
         sps_pkg::OP_RES_COMMIT: begin
            nslot_in   = 12'(pe_ff);
            cb_in      = PW'(wloc_ff);
            pe_in      = pe_ff + PW'(sps_pkg::SLOT_BYTES);
            space_in   = PW'(EW'(wloc_ff) - EW'(pe_ff) - EW'(sps_pkg::SLOT_BYTES));
            cursor_in  = PW'(wloc_ff);
            pending_in = 14'(wsize_ff);
         end
         sps_pkg::OP_BYTE_WR: begin
            mem_we     = (EW'(cursor_ff) < EW'(PAGE_BYTES));
            mem_wa     = AW'(cursor_ff);
            mem_wd     = dbyte_ff;
            cursor_in  = cursor_ff + PW'(1);
            pending_in = pending_ff - 14'd1;
         end
         sps_pkg::OP_RD_CHECK: begin
            slen_in = 13'(size_ff);
            mem_ra  = AW'(EW'(loc_ff) + EW'(bidx_ff));
            if (loc_ff == 16'd0) begin
               res_in = sps_pkg::RS_ABSENT;
            end else if ({4'd0, bidx_ff} >= size_ff) begin
               res_in = sps_pkg::RS_BAD;
            end else begin
               mem_re = 1'b1;
            end
         end
         sps_pkg::OP_RD_DATA: begin
            rdata_in = rd_q_ff;
         end
         sps_pkg::OP_CMP_START: begin
            rbase_in     = PW'(HEADER_BYTES);
            wbase_in     = PW'(HEADER_BYTES);
            wloc_in      = 16'(PAGE_BYTES - 1);
            old_pe_in    = pe_ff;
            old_cb_in    = cb_ff;
            last_live_in = 1'b0;
         end
         sps_pkg::OP_CMP_SKIP: begin
            rbase_in = rbase_ff + PW'(sps_pkg::SLOT_BYTES);
         end
         sps_pkg::OP_CMP_PLACE: begin
            wloc_in  = wloc_ff - size_ff;
            wsize_in = size_ff;
            cnt_in   = size_ff;
         end
         sps_pkg::OP_MV_RD: begin
            // highest byte first: cells only move up
            mem_re = 1'b1;
            mem_ra = AW'(EW'(loc_ff) + EW'(cnt_ff) - EW'(1));
         end
         sps_pkg::OP_MV_WR: begin
            mem_we = 1'b1;
            mem_wa = AW'(EW'(wloc_ff) + EW'(cnt_ff) - EW'(1));
            mem_wd = rd_q_ff;
            cnt_in = cnt_ff - 16'd1;
         end
         sps_pkg::OP_CMP_ADV: begin
            wbase_in = wbase_ff + PW'(sps_pkg::SLOT_BYTES);
            rbase_in = rbase_ff + PW'(sps_pkg::SLOT_BYTES);
            if (EW'(rbase_ff) + EW'(sps_pkg::SLOT_BYTES) == EW'(old_pe_ff)) begin
               last_live_in = 1'b1;
               last_loc_in  = wloc_ff;
               last_size_in = wsize_ff;
            end
         end
         sps_pkg::OP_Z1_START: begin
            clr_in = wbase_ff;
         end
         sps_pkg::OP_Z2_START: begin
            clr_in = old_cb_ff;
         end
         sps_pkg::OP_CMP_FINISH: begin
            pe_in    = wbase_ff;
            cb_in    = PW'(wloc_ff);
            space_in = PW'(EW'(wloc_ff) - EW'(wbase_ff));
            dirty_in = 1'b0;
            if (pending_ff != 14'd0) begin
               if (last_live_ff && (EW'(pending_ff) <= EW'(last_size_ff))) begin
                  cursor_in = PW'(EW'(last_loc_ff) + EW'(last_size_ff) - EW'(pending_ff));
               end else begin
                  pending_in = 14'd0;
                  cursor_in  = '0;
               end
            end
         end
         sps_pkg::OP_RESP: begin
            rsp_valid_in = 1'b1;
            out_user_in  = res_ff;
            out_data_in  = {1'b0, dirty_ff, 13'(space_ff), slen_ff, rdata_ff, nslot_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_q_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pe_ff        <= PW'(HEADER_BYTES);
         cb_ff        <= PW'(PAGE_BYTES - 1);
         space_ff     <= PW'(PAGE_BYTES - 1 - HEADER_BYTES);
         cursor_ff    <= '0;
         dirty_ff     <= 1'b0;
         pending_ff   <= 14'd0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= 2'd0;
         res_ff       <= sps_pkg::RS_OK;
      end else begin
         pe_ff        <= pe_in;
         cb_ff        <= cb_in;
         space_ff     <= space_in;
         cursor_ff    <= cursor_in;
         dirty_ff     <= dirty_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         res_ff       <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      dbyte_ff     <= dbyte_in;
      bidx_ff      <= bidx_in;
      nslot_ff     <= nslot_in;
      rdata_ff     <= rdata_in;
      slen_ff      <= slen_in;
      wbase_ff     <= wbase_in;
      rbase_ff     <= rbase_in;
      clr_ff       <= clr_in;
      old_pe_ff    <= old_pe_in;
      old_cb_ff    <= old_cb_in;
      wloc_ff      <= wloc_in;
      wsize_ff     <= wsize_in;
      loc_ff       <= loc_in;
      size_ff      <= size_in;
      cnt_ff       <= cnt_in;
      last_loc_ff  <= last_loc_in;
      last_size_ff <= last_size_in;
      last_live_ff <= last_live_in;
      out_data_ff  <= out_data_in;
      out_user_ff  <= out_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

>>> tb/tb_slotted_page_cell_store_core.sv
// testbench for slotted_page_cell_store_core: directed table, then constrained-by-hand random
// requests checked field by field against an in-bench page predictor; depends on sps_pkg
module tb_slotted_page_cell_store_core;

   localparam int PAGE = 4096;
   localparam int HDR = 16;
   localparam int CYCLE_LIMIT = 4000000;
   localparam logic [2:0] FN_SPARE_A = 3'd6;
   localparam logic [2:0] FN_SPARE_B = 3'd7;
   localparam int IDLE_SENDER = 0;
   localparam int IDLE_RECEIVER = 1;
   localparam int IDLE_NONE = 2;

   typedef struct packed {
      logic [2:0]  func;
      logic [12:0] cell_len;
      logic [7:0]  data_byte;
      logic [11:0] slot_offset;
      logic [11:0] byte_index;
   } page_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] new_slot;
      logic [7:0]  read_data;
      logic [12:0] stored_len;
      logic [12:0] free_bytes;
      logic        pending;
   } page_result_type;

   typedef struct {
      page_req_type    req;
      bit              typed;
      page_result_type want;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   slotted_page_cell_store_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // predicted page state
   logic [7:0]  pg [0:PAGE-1];
   logic [7:0]  scr [0:PAGE-1];
   int unsigned ptr_end, cell_beg, space, dirty, wcur, pend;

   page_result_type result_q [$];
   plan_row_type    plan [$];
   int errors = 0;
   int idle_mode = IDLE_SENDER;
   int hold_cycles = 0;
   longint cycles = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("slotted_page_cell_store_core test failed");
         $finish;
      end
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int unsigned get16(int unsigned a);
      int unsigned lo, hi;
      lo = (a < PAGE) ? pg[a] : 0;
      hi = (a + 1 < PAGE) ? pg[a + 1] : 0;
      return lo | (hi << 8);
   endfunction

   function automatic void put16(int unsigned a, int unsigned v);
      if (a < PAGE) pg[a] = v[7:0];
      if (a + 1 < PAGE) pg[a + 1] = v[15:8];
   endfunction

   function automatic void clear_page();
      for (int i = 0; i < PAGE; i++) pg[i] = 8'h00;
      ptr_end = HDR;
      cell_beg = PAGE - 1;
      space = cell_beg - ptr_end;
      dirty = 0;
      wcur = 0;
      pend = 0;
   endfunction

   function automatic bit slot_valid(int unsigned off);
      if (off < HDR || off + sps_pkg::SLOT_BYTES > ptr_end) return 0;
      return ((off - HDR) % sps_pkg::SLOT_BYTES) == 0;
   endfunction

   function automatic void repack_page();
      int unsigned ns, ne, s, loc, sz, last_loc, last_sz;
      bit last_live;
      ns = HDR;
      ne = PAGE - 1;
      last_live = 0;
      last_loc = 0;
      last_sz = 0;
      for (int i = 0; i < PAGE; i++) scr[i] = 8'h00;
      for (s = HDR; s + sps_pkg::SLOT_BYTES <= ptr_end; s += sps_pkg::SLOT_BYTES) begin
         loc = get16(s);
         sz = get16(s + 2);
         if (loc == 0) continue;
         if (ne < ns || ne - ns < sz + sps_pkg::SLOT_BYTES) break;
         ne -= sz;
         for (int unsigned i = 0; i < sz; i++)
            if (loc + i < PAGE && ne + i < PAGE) scr[ne + i] = pg[loc + i];
         scr[ns] = ne[7:0];
         scr[ns + 1] = ne[15:8];
         scr[ns + 2] = sz[7:0];
         scr[ns + 3] = sz[15:8];
         ns += sps_pkg::SLOT_BYTES;
         if (s + sps_pkg::SLOT_BYTES == ptr_end) begin
            last_live = 1;
            last_loc = ne;
            last_sz = sz;
         end
      end
      for (int i = HDR; i < PAGE; i++) pg[i] = scr[i];
      ptr_end = ns;
      cell_beg = ne;
      space = cell_beg - ptr_end;
      dirty = 0;
      if (pend != 0) begin
         if (last_live && pend <= last_sz) wcur = last_loc + (last_sz - pend);
         else begin
            pend = 0;
            wcur = 0;
         end
      end
   endfunction

   function automatic page_result_type apply_request(page_req_type q);
      page_result_type r;
      int unsigned csz, loc, slen;
      r = '0;
      csz = 32'(q.cell_len);
      case (q.func)
         sps_pkg::FN_INIT: clear_page();
         sps_pkg::FN_RESERVE: begin
            if (space < csz + sps_pkg::SLOT_BYTES) r.status = sps_pkg::RS_NO_ROOM;
            else begin
               loc = cell_beg - csz;
               put16(ptr_end, loc);
               put16(ptr_end + 2, csz);
               r.new_slot = 12'(ptr_end);
               cell_beg = loc;
               ptr_end += sps_pkg::SLOT_BYTES;
               space = cell_beg - ptr_end;
               wcur = loc;
               pend = csz;
            end
         end
         sps_pkg::FN_WRITE: begin
            if (pend == 0) r.status = sps_pkg::RS_BAD;
            else begin
               if (wcur < PAGE) pg[wcur] = q.data_byte;
               wcur++;
               pend--;
            end
         end
         sps_pkg::FN_REMOVE: begin
            if (!slot_valid(32'(q.slot_offset))) r.status = sps_pkg::RS_BAD;
            else begin
               dirty = 1;
               put16(32'(q.slot_offset), 0);
            end
         end
         sps_pkg::FN_READ: begin
            if (!slot_valid(32'(q.slot_offset))) r.status = sps_pkg::RS_BAD;
            else begin
               loc = get16(32'(q.slot_offset));
               slen = get16(32'(q.slot_offset) + 2);
               r.stored_len = 13'(slen);
               if (loc == 0) r.status = sps_pkg::RS_ABSENT;
               else if (32'(q.byte_index) >= slen) r.status = sps_pkg::RS_BAD;
               else if (loc + 32'(q.byte_index) < PAGE)
                  r.read_data = pg[loc + 32'(q.byte_index)];
            end
         end
         sps_pkg::FN_COMPACT: if (dirty != 0) repack_page();
         default: r.status = sps_pkg::RS_BAD;
      endcase
      r.free_bytes = 13'(space);
      r.pending = dirty[0];
      return r;
   endfunction

   function automatic page_req_type next_request();
      page_req_type r;
      int unsigned nslots, s, sz, p;
      r = '0;
      r.func = 3'($urandom);
      r.cell_len = 13'($urandom);
      r.data_byte = 8'($urandom);
      r.slot_offset = 12'($urandom);
      r.byte_index = 12'($urandom);
      nslots = (ptr_end - HDR) / sps_pkg::SLOT_BYTES;
      s = (nslots == 0) ? 32'(r.slot_offset)
                        : HDR + sps_pkg::SLOT_BYTES * $urandom_range(0, nslots - 1);
      p = $urandom_range(0, 99);
      if (pend > 0 && p < 80) begin
         r.func = sps_pkg::FN_WRITE;
         return r;
      end
      p = $urandom_range(0, 99);
      if (space < 40 && p < 30) r.func = (p < 15) ? sps_pkg::FN_COMPACT : sps_pkg::FN_INIT;
      else if (p < 1) r.func = sps_pkg::FN_INIT;
      else if (p < 5) r.func = sps_pkg::FN_COMPACT;
      else if (p < 30) begin
         r.func = sps_pkg::FN_RESERVE;
         p = $urandom_range(0, 99);
         if (p < 85) r.cell_len = 13'($urandom_range(0, 24));
         else if (p < 97) r.cell_len = 13'($urandom_range(0, 300));
      end
      else if (p < 35) begin
         // noise, any code
      end
      else if (p < 80) begin
         r.func = sps_pkg::FN_READ;
         if ($urandom_range(0, 9) < 9) r.slot_offset = 12'(s);
         sz = get16(s + 2);
         if (sz > 0 && $urandom_range(0, 9) < 8)
            r.byte_index = 12'($urandom_range(0, sz - 1));
      end
      else if (p < 90) begin
         r.func = sps_pkg::FN_REMOVE;
         if ($urandom_range(0, 9) < 8) r.slot_offset = 12'(s);
      end
      else r.func = sps_pkg::FN_WRITE;
      return r;
   endfunction

   task automatic send_request(page_req_type q, bit typed, page_result_type want);
      page_result_type got;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, q.byte_index, q.slot_offset, q.data_byte, q.cell_len};
      req_tuser <= q.func;
      do @(posedge clock); while (!req_tready);
      got = apply_request(q);
      result_q.push_back(typed ? want : got);
   endtask

   task automatic sender_gap(int n);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic random_gap();
      if (idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 25)
         sender_gap($urandom_range(1, 3));
      else if (idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 84)
         sender_gap($urandom_range(1, 3));
   endtask

   function automatic void add_row(logic [2:0] f, int csz, int db, int so, int bi,
                                   bit typed = 0,
                                   sps_pkg::result_type st = sps_pkg::RS_OK,
                                   int ns = 0, int fr = 0, bit pd = 0);
      plan_row_type row;
      row.req = '{func: f, cell_len: 13'(csz), data_byte: 8'(db), slot_offset: 12'(so),
                  byte_index: 12'(bi)};
      row.typed = typed;
      row.want = '{status: st, new_slot: 12'(ns), read_data: 8'd0, stored_len: 13'd0,
                   free_bytes: 13'(fr), pending: pd};
      plan.push_back(row);
   endfunction

   // receiver side
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end
         else if (idle_mode == IDLE_SENDER) rsp_tready <= ($urandom_range(0, 99) >= 84);
         else if (idle_mode == IDLE_RECEIVER) rsp_tready <= ($urandom_range(0, 99) >= 25);
         else rsp_tready <= 1'b1;
      end
   end

   // result checking
   always @(posedge clock) begin : check_results
      page_result_type e, g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         g = '{status: rsp_tuser, new_slot: rsp_tdata[11:0], read_data: rsp_tdata[19:12],
               stored_len: rsp_tdata[32:20], free_bytes: rsp_tdata[45:33],
               pending: rsp_tdata[46]};
         if (result_q.size() == 0) report_mismatch("unexpected transfer", 1, 0);
         else begin
            e = result_q.pop_front();
            if (g.status !== e.status) report_mismatch("status", g.status, e.status);
            if (g.new_slot !== e.new_slot)
               report_mismatch("new_slot_offset", g.new_slot, e.new_slot);
            if (g.read_data !== e.read_data)
               report_mismatch("read_data", g.read_data, e.read_data);
            if (g.stored_len !== e.stored_len)
               report_mismatch("stored_length", g.stored_len, e.stored_len);
            if (g.free_bytes !== e.free_bytes)
               report_mismatch("free_bytes", g.free_bytes, e.free_bytes);
            if (g.pending !== e.pending)
               report_mismatch("compact_pending", g.pending, e.pending);
            if (rsp_tdata[47] !== 1'b0) report_mismatch("rsp_tdata pad", rsp_tdata[47], 0);
         end
      end
   end

   initial begin : stimulus
      page_result_type none;
      none = '0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      clear_page();

      add_row(sps_pkg::FN_READ, 0, 0, 16, 0, 1, sps_pkg::RS_BAD, 0, 4079);
      add_row(sps_pkg::FN_WRITE, 0, 0, 0, 0, 1, sps_pkg::RS_BAD, 0, 4079);
      add_row(sps_pkg::FN_COMPACT, 0, 0, 0, 0, 1, sps_pkg::RS_OK, 0, 4079);
      add_row(FN_SPARE_A, 0, 0, 0, 0, 1, sps_pkg::RS_BAD, 0, 4079);
      add_row(FN_SPARE_B, 8191, 255, 4095, 4095, 1, sps_pkg::RS_BAD, 0, 4079);
      add_row(sps_pkg::FN_RESERVE, 4096, 0, 0, 0, 1, sps_pkg::RS_NO_ROOM, 0, 4079);
      add_row(sps_pkg::FN_RESERVE, 0, 0, 0, 0, 1, sps_pkg::RS_OK, 16, 4075);
      add_row(sps_pkg::FN_RESERVE, 3, 0, 0, 0, 1, sps_pkg::RS_OK, 20, 4068);
      add_row(sps_pkg::FN_WRITE, 0, 255, 0, 0);
      add_row(sps_pkg::FN_WRITE, 0, 0, 0, 0);
      add_row(sps_pkg::FN_RESERVE, 2, 0, 0, 0);
      add_row(sps_pkg::FN_WRITE, 0, 8'hAA, 0, 0);
      add_row(sps_pkg::FN_WRITE, 0, 8'h55, 0, 0);
      add_row(sps_pkg::FN_READ, 0, 0, 20, 0);
      add_row(sps_pkg::FN_READ, 0, 0, 20, 4095);
      add_row(sps_pkg::FN_READ, 0, 0, 21, 0);
      add_row(sps_pkg::FN_READ, 0, 0, 4095, 0);
      add_row(sps_pkg::FN_READ, 0, 0, 16, 0);
      add_row(sps_pkg::FN_REMOVE, 0, 0, 20, 0);
      add_row(sps_pkg::FN_REMOVE, 0, 0, 20, 0);
      add_row(sps_pkg::FN_READ, 0, 0, 20, 0);
      add_row(sps_pkg::FN_COMPACT, 0, 0, 0, 0);
      add_row(sps_pkg::FN_READ, 0, 0, 20, 1);
      add_row(sps_pkg::FN_INIT, 0, 0, 0, 0, 1, sps_pkg::RS_OK, 0, 4079);
      add_row(sps_pkg::FN_RESERVE, 4075, 0, 0, 0, 1, sps_pkg::RS_OK, 16, 0);
      add_row(sps_pkg::FN_RESERVE, 0, 0, 0, 0, 1, sps_pkg::RS_NO_ROOM, 0, 0);
      add_row(sps_pkg::FN_INIT, 0, 0, 0, 0, 1, sps_pkg::RS_OK, 0, 4079);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         send_request(plan[i].req, plan[i].typed, plan[i].want);
         random_gap();
      end

      for (int n = 0; n < 1400; n++) begin
         if (n == 470) idle_mode = IDLE_RECEIVER;
         if (n == 940) idle_mode = IDLE_NONE;
         if (n == 700) hold_cycles = 400;
         if (n == 720 || n == 1100) begin
            sender_gap(1);
            wait (result_q.size() == 0);
         end
         send_request(next_request(), 0, none);
         random_gap();
      end
      sender_gap(1);
      wait (result_q.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("slotted_page_cell_store_core test passed");
      else $display("slotted_page_cell_store_core test failed");
      $finish;
   end
endmodule

>>> filelist.f
src/sps_pkg.sv
src/sps_ctrl.sv
src/sps_datapath.sv
src/slotted_page_cell_store_core.sv
tb/tb_slotted_page_cell_store_core.sv
